/* design/jsfr_pkg.sv */
// shared types and constants of the json object stream framer
`timescale 1ns / 1ps

package jsfr_pkg;

   // brace depth limit and the saturation point of the 8 bit depth counter
   localparam int DEPTH_LIMIT = 255;
   localparam int EFFECTIVE_DEPTH_LIMIT = (DEPTH_LIMIT < 255) ? DEPTH_LIMIT : 255;
   localparam logic [7:0] DEPTH_MAX = 8'(EFFECTIVE_DEPTH_LIMIT);

   // reset value of the frame length limit
   localparam logic [15:0] MAX_FRAME_RESET = 16'd16384;

   // byte codes that steer framing
   localparam logic [7:0] CH_OPEN      = 8'h7B;
   localparam logic [7:0] CH_CLOSE     = 8'h7D;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // queue sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_QUOTE,
      CLS_BACKSLASH
   } byte_class_type;

   // classified item handed from front end to back end
   typedef struct packed {
      logic [7:0]     data_byte;
      byte_class_type cls;
   } class_item_type;

   // head of the classified queue as seen by the back end
   typedef struct packed {
      logic           valid;
      class_item_type item;
   } class_head_type;

   // one result item
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        kept;
      logic        frame_start;
      logic        frame_end;
      logic [15:0] frame_length;
      logic [7:0]  nesting_depth;
      logic        inside_string;
      logic        depth_overflow;
   } rsp_item_type;

endpackage

/* design/jsfr_front.sv */
// front end: classifies incoming bytes and buffers them in a short queue
`timescale 1ns / 1ps

module jsfr_front import jsfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [7:0]     req_rx_byte,
   output class_head_type head,
   input  logic           head_take
);

   class_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;
   logic                  wr_en;
   logic                  rd_en;
   class_item_type        new_item;

   // byte classification
   always_comb begin
      new_item.data_byte = req_rx_byte;
      unique case (req_rx_byte)
         CH_OPEN:      new_item.cls = CLS_OPEN;
         CH_CLOSE:     new_item.cls = CLS_CLOSE;
         CH_QUOTE:     new_item.cls = CLS_QUOTE;
         CH_BACKSLASH: new_item.cls = CLS_BACKSLASH;
         default:      new_item.cls = CLS_OTHER;
      endcase
   end

   // queue handshake
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign wr_en      = push && !full;
   assign rd_en      = head_take && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* design/jsfr_back.sv */
// back end: brace, string and length tracking plus the result queue
`timescale 1ns / 1ps

module jsfr_back import jsfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [15:0]    csr_wr_data,
   input  class_head_type head,
   output logic           head_take,
   output logic           empty,
   input  logic           pop,
   output rsp_item_type   rsp_item
);

   logic [15:0]       max_frame_ff;
   logic [7:0]        depth_ff;
   logic [7:0]        depth_in;
   logic              string_ff;
   logic              string_in;
   logic              escape_ff;
   logic              escape_in;
   logic [15:0]       kept_count_ff;
   logic [15:0]       kept_count_in;
   rsp_item_type      res;

   rsp_item_type      out_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] out_wr_ptr_ff;
   logic [QPTR_W-1:0] out_rd_ptr_ff;
   logic [QCNT_W-1:0] out_count_ff;
   logic [QCNT_W-1:0] out_count_in;
   logic              out_push;
   logic              out_pop;

   // take a classified byte whenever the result queue has room
   assign head_take = head.valid && (out_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_push  = head_take;
   assign out_pop   = pop && !empty;
   assign empty     = (out_count_ff == '0);
   assign rsp_item  = out_ff[out_rd_ptr_ff];

   // per-byte framing step
   always_comb begin
      depth_in      = depth_ff;
      string_in     = string_ff;
      escape_in     = escape_ff;
      kept_count_in = kept_count_ff;
      res           = '0;
      res.data_byte = head.item.data_byte;
      if (depth_ff == '0) begin
         if (head.item.cls == CLS_OPEN) begin
            depth_in        = 8'd1;
            string_in       = 1'b0;
            escape_in       = 1'b0;
            kept_count_in   = 16'd1;
            res.kept        = 1'b1;
            res.frame_start = 1'b1;
         end else begin
            kept_count_in = '0;
         end
         res.frame_length = kept_count_in;
      end else begin
         if (kept_count_ff < max_frame_ff) begin
            kept_count_in = kept_count_ff + 16'd1;
            res.kept      = 1'b1;
         end
         res.frame_length = kept_count_in;
         priority if (escape_ff) begin
            escape_in = 1'b0;
         end else if (string_ff && head.item.cls == CLS_BACKSLASH) begin
            escape_in = 1'b1;
         end else if (head.item.cls == CLS_QUOTE) begin
            string_in = !string_ff;
         end else if (!string_ff && head.item.cls == CLS_OPEN) begin
            if (depth_ff >= DEPTH_MAX) begin
               res.depth_overflow = 1'b1;
            end else begin
               depth_in = depth_ff + 8'd1;
            end
         end else if (!string_ff && head.item.cls == CLS_CLOSE) begin
            depth_in = depth_ff - 8'd1;
            if (depth_in == '0) begin
               res.frame_end = 1'b1;
               kept_count_in = '0;
               string_in     = 1'b0;
               escape_in     = 1'b0;
            end
         end else begin
            escape_in = escape_ff;
         end
      end
      res.nesting_depth = depth_in;
      res.inside_string = string_in;
   end

   // framing state and length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff  <= MAX_FRAME_RESET;
         depth_ff      <= '0;
         string_ff     <= 1'b0;
         escape_ff     <= 1'b0;
         kept_count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            max_frame_ff <= csr_wr_data;
         end
         if (head_take) begin
            depth_ff      <= depth_in;
            string_ff     <= string_in;
            escape_ff     <= escape_in;
            kept_count_ff <= kept_count_in;
         end
      end
   end

   // result queue control
   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + QCNT_W'(1);
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         if (out_push) begin
            out_wr_ptr_ff <= out_wr_ptr_ff + QPTR_W'(1);
         end
         if (out_pop) begin
            out_rd_ptr_ff <= out_rd_ptr_ff + QPTR_W'(1);
         end
         out_count_ff <= out_count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ptr_ff] <= res;
      end
   end

   // outside a frame the kept count is always zero
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      depth_ff == '0 |-> kept_count_ff == '0)
      else $error("kept count nonzero outside a frame");

   // an escape is only pending inside a string
   a_escape_in_string: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> string_ff)
      else $error("escape flag set outside a string");

   // a frame start item is kept with length one at depth one
   a_start_shape: assert property (@(posedge clock) disable iff (reset)
      out_push && res.frame_start |->
         res.kept && res.frame_length == 16'd1 && res.nesting_depth == 8'd1)
      else $error("malformed frame start item");

   // a frame end leaves the tracker outside any frame
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      out_push && res.frame_end |=> depth_ff == '0 && !string_ff)
      else $error("frame end did not close the frame");

   // the result queue never overfills
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

endmodule

/* design/json_object_stream_framer.sv */
// top level of the json object stream framer
`timescale 1ns / 1ps

// Cuts complete top-level JSON objects out of a byte stream and returns one
// result item per accepted byte, in order. Bytes are pushed while full is low
// and results are popped while empty is low. A byte is classified and held in
// a four-entry front queue, then the back end applies the brace, string and
// length step to it and places the result in a four-entry result queue. The
// result of an accepted byte passes both queues before it can be popped; one
// byte per cycle is sustained while the result queue has room. The user writes
// the frame length limit (reset 16384) through csr_wr_en and csr_wr_data only
// while no item is in flight; the block itself does not enforce this.
module json_object_stream_framer import jsfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_kept,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   output logic [15:0] rsp_frame_length,
   output logic [7:0]  rsp_nesting_depth,
   output logic        rsp_inside_string,
   output logic        rsp_depth_overflow,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   class_head_type head;
   logic           head_take;
   rsp_item_type   rsp_item;

   // classify and buffer incoming items
   jsfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_rx_byte (req_rx_byte),
      .head        (head),
      .head_take   (head_take)
   );

   // framing state and result queue
   jsfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .head_take   (head_take),
      .empty       (empty),
      .pop         (pop),
      .rsp_item    (rsp_item)
   );

   // result fields
   assign rsp_data_byte      = rsp_item.data_byte;
   assign rsp_kept           = rsp_item.kept;
   assign rsp_frame_start    = rsp_item.frame_start;
   assign rsp_frame_end      = rsp_item.frame_end;
   assign rsp_frame_length   = rsp_item.frame_length;
   assign rsp_nesting_depth  = rsp_item.nesting_depth;
   assign rsp_inside_string  = rsp_item.inside_string;
   assign rsp_depth_overflow = rsp_item.depth_overflow;

endmodule

/* tb/sv/json_object_stream_framer_checker.sv */
// checker that predicts and compares the result items of the json object stream framer
`timescale 1ns / 1ps

module json_object_stream_framer_checker import jsfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_kept,
   input  logic        rsp_frame_start,
   input  logic        rsp_frame_end,
   input  logic [15:0] rsp_frame_length,
   input  logic [7:0]  rsp_nesting_depth,
   input  logic        rsp_inside_string,
   input  logic        rsp_depth_overflow,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          error_count,
   output int          results_due
);

   // framing state tracked beside the block
   logic [7:0]  depth       = '0;
   logic        in_str      = 1'b0;
   logic        esc         = 1'b0;
   logic [15:0] kept_cnt    = '0;
   logic [15:0] frame_limit = MAX_FRAME_RESET;

   rsp_item_type framed_q[$];
   int           errors  = 0;
   int           due_cnt = 0;

   assign error_count = errors;
   assign results_due = due_cnt;

   // one byte through brace, string and length tracking
   function automatic rsp_item_type frame_byte(input logic [7:0] c);
      rsp_item_type r;
      r = '0;
      r.data_byte = c;
      if (depth == 8'd0) begin
         if (c == CH_OPEN) begin
            depth         = 8'd1;
            in_str        = 1'b0;
            esc           = 1'b0;
            kept_cnt      = 16'd1;
            r.kept        = 1'b1;
            r.frame_start = 1'b1;
         end else begin
            kept_cnt = '0;
         end
         r.frame_length = kept_cnt;
      end else begin
         if (kept_cnt < frame_limit) begin
            kept_cnt = kept_cnt + 16'd1;
            r.kept   = 1'b1;
         end
         r.frame_length = kept_cnt;
         if (esc) begin
            esc = 1'b0;
         end else if (in_str && c == CH_BACKSLASH) begin
            esc = 1'b1;
         end else if (c == CH_QUOTE) begin
            in_str = !in_str;
         end else if (!in_str) begin
            if (c == CH_OPEN) begin
               // saturate at the depth limit and flag it
               if (depth >= DEPTH_MAX) r.depth_overflow = 1'b1;
               else depth = depth + 8'd1;
            end else if (c == CH_CLOSE) begin
               depth = depth - 8'd1;
               if (depth == 8'd0) begin
                  r.frame_end = 1'b1;
                  kept_cnt    = '0;
                  in_str      = 1'b0;
                  esc         = 1'b0;
               end
            end
         end
      end
      r.nesting_depth = depth;
      r.inside_string = in_str;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         depth       = '0;
         in_str      = 1'b0;
         esc         = 1'b0;
         kept_cnt    = '0;
         frame_limit = MAX_FRAME_RESET;
         framed_q.delete();
      end else begin
         if (csr_wr_en) frame_limit = csr_wr_data;

         // compare a popped item with the oldest prediction
         if (pop && !empty) begin
            if (framed_q.size() == 0) begin
               $display("%0t: result expected none actual data_byte %h",
                        $time, rsp_data_byte);
               errors++;
            end else begin
               want = framed_q.pop_front();
               check_field("data_byte", 16'(want.data_byte), 16'(rsp_data_byte));
               check_field("kept", 16'(want.kept), 16'(rsp_kept));
               check_field("frame_start", 16'(want.frame_start), 16'(rsp_frame_start));
               check_field("frame_end", 16'(want.frame_end), 16'(rsp_frame_end));
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("nesting_depth", 16'(want.nesting_depth),
                           16'(rsp_nesting_depth));
               check_field("inside_string", 16'(want.inside_string),
                           16'(rsp_inside_string));
               check_field("depth_overflow", 16'(want.depth_overflow),
                           16'(rsp_depth_overflow));
            end
         end

         // predict the result of a pushed item
         if (push && !full) framed_q.push_back(frame_byte(req_rx_byte));
      end
      due_cnt <= framed_q.size();
   end

endmodule

/* tb/sv/json_object_stream_framer_tb.sv */
// top of the json object stream framer testbench: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module json_object_stream_framer_tb import jsfr_pkg::*;;

   localparam int STALL_LIMIT = 4000;

   // object with an escaped quote, an escaped backslash and a brace inside a string
   localparam logic [7:0] ESC_OBJ [11] = '{
      CH_OPEN, CH_QUOTE, CH_BACKSLASH, CH_QUOTE, CH_CLOSE, CH_BACKSLASH,
      CH_BACKSLASH, CH_QUOTE, CH_OPEN, CH_CLOSE, CH_CLOSE
   };
   // bytes outside any frame, the field extremes among them
   localparam logic [7:0] NOISE_SEQ [5] = '{
      8'h00, 8'hFF, CH_CLOSE, CH_QUOTE, CH_BACKSLASH
   };

   logic        clock;
   logic        reset       = 1'b1;
   logic        push        = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = '0;
   logic        empty;
   logic        pop         = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_kept;
   logic        rsp_frame_start;
   logic        rsp_frame_end;
   logic [15:0] rsp_frame_length;
   logic [7:0]  rsp_nesting_depth;
   logic        rsp_inside_string;
   logic        rsp_depth_overflow;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   int errors;
   int outstanding;
   int send_idle_pct = 0;
   int pop_idle_pct  = 0;
   int bytes_sent    = 0;
   int stall_cycles  = 0;

   json_object_stream_framer dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_rx_byte        (req_rx_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_kept           (rsp_kept),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_nesting_depth  (rsp_nesting_depth),
      .rsp_inside_string  (rsp_inside_string),
      .rsp_depth_overflow (rsp_depth_overflow),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   json_object_stream_framer_checker framer_check (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_rx_byte        (req_rx_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_kept           (rsp_kept),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_nesting_depth  (rsp_nesting_depth),
      .rsp_inside_string  (rsp_inside_string),
      .rsp_depth_overflow (rsp_depth_overflow),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .error_count        (errors),
      .results_due        (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver pops at random
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   // cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("json_object_stream_framer_tb failed");
      $finish;
   end

   // push one byte, with random idle cycles first
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
   endtask

   // hold the sender until every result is back
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [15:0] v);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // any byte but the braces and the quote
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (b == CH_OPEN || b == CH_CLOSE || b == CH_QUOTE) b = 8'($urandom_range(255));
      return b;
   endfunction

   // byte weighted toward the framing codes
   function automatic logic [7:0] rough_byte();
      int r;
      r = $urandom_range(99);
      if (r < 12) return CH_OPEN;
      if (r < 24) return CH_CLOSE;
      if (r < 34) return CH_QUOTE;
      if (r < 44) return CH_BACKSLASH;
      return 8'($urandom_range(255));
   endfunction

   // quoted string with escapes and stray braces
   task automatic send_string();
      int len;
      len = $urandom_range(0, 8);
      send_byte(CH_QUOTE);
      repeat (len) begin
         if ($urandom_range(99) < 20) begin
            send_byte(CH_BACKSLASH);
            send_byte(8'($urandom_range(255)));
         end else begin
            send_byte($urandom_range(99) < 15 ? rough_byte() : plain_byte());
         end
      end
      send_byte(CH_QUOTE);
   endtask

   // balanced object with random content
   task automatic send_object(input int body_len);
      int lvl;
      int n;
      int r;
      lvl = 1;
      n   = 0;
      send_byte(CH_OPEN);
      while (lvl > 0) begin
         r = $urandom_range(99);
         if (n >= body_len || (r >= 15 && r < 28)) begin
            send_byte(CH_CLOSE);
            lvl--;
         end else if (r < 15) begin
            send_byte(CH_OPEN);
            lvl++;
         end else if (r < 50) begin
            send_string();
         end else begin
            send_byte(plain_byte());
         end
         n++;
      end
   endtask

   // nest past the depth limit, then close all the way out
   task automatic send_deep_object();
      repeat (int'(DEPTH_MAX) + 3) send_byte(CH_OPEN);
      repeat (int'(DEPTH_MAX) + 3) send_byte(CH_CLOSE);
   endtask

   // mix of objects, noise outside frames and broken sequences
   task automatic run_traffic(input int n_bytes);
      int start;
      int r;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         r = $urandom_range(99);
         if (r < 70) begin
            send_object($urandom_range(99) < 5 ? 40 : $urandom_range(0, 12));
         end else if (r < 85) begin
            repeat ($urandom_range(1, 4)) begin
               r = $urandom_range(255);
               send_byte(r == CH_OPEN ? CH_CLOSE : 8'(r));
            end
         end else begin
            repeat ($urandom_range(1, 10)) send_byte(rough_byte());
         end
         if ($urandom_range(99) < 2) wait_drained();
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero length limit keeps only the opening brace
      write_frame_limit(16'h0000);
      send_byte(CH_OPEN);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_CLOSE);

      write_frame_limit(16'h0001);
      send_byte(CH_OPEN);
      send_byte(8'h61);
      send_byte(CH_CLOSE);

      write_frame_limit(16'hFFFF);
      foreach (NOISE_SEQ[i]) send_byte(NOISE_SEQ[i]);
      foreach (ESC_OBJ[i]) send_byte(ESC_OBJ[i]);

      // sender light, receiver heavy idling; short frame limit
      send_idle_pct = 18;
      pop_idle_pct  = 81;
      write_frame_limit(16'($urandom_range(2, 24)));
      send_deep_object();
      run_traffic(200);

      // sender heavy, receiver light idling
      send_idle_pct = 81;
      pop_idle_pct  = 18;
      write_frame_limit(16'hFFFF);
      run_traffic(300);

      // no idling
      send_idle_pct = 0;
      pop_idle_pct  = 0;
      write_frame_limit(MAX_FRAME_RESET);
      run_traffic(230);
      write_frame_limit(16'($urandom_range(1, 6)));
      run_traffic(230);

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) $display("json_object_stream_framer_tb passed");
      else $display("json_object_stream_framer_tb failed");
      $finish;
   end

endmodule
